// ===== src/psag_pkg.sv =====
// ----------------------------------------------------------------------------
// psag_pkg
// Types, codes and constants shared by the plane slice address generator.
// ----------------------------------------------------------------------------
package psag_pkg;

    localparam int MAX_DIMS   = 4;
    localparam int DIM_W      = 16;
    localparam int NUM_SIZES  = 4;
    localparam int OUT_W      = 32;
    localparam int CFG_DATA_W = 64;
    localparam int ADDR_W     = 6;
    localparam int REG_SEL_W  = 3;

    typedef enum logic [REG_SEL_W-1:0] {
        REG_DIM_SIZES    = 3'd0,
        REG_NUM_DIMS     = 3'd1,
        REG_FIRST_DIM    = 3'd2,
        REG_SECOND_DIM   = 3'd3,
        REG_ORIGIN_INDEX = 3'd4,
        REG_DIRECTION    = 3'd5
    } cfg_reg_t;

    typedef enum logic [1:0] {
        DIR_A2S = 2'd0,
        DIR_S2A = 2'd1
    } dir_t;

    typedef enum logic [1:0] {
        MOVE_NONE = 2'd0,
        MOVE_A2S  = 2'd1,
        MOVE_S2A  = 2'd2
    } move_t;

    typedef enum logic [1:0] {
        ERR_OK     = 2'd0,
        ERR_ORDER  = 2'd1,
        ERR_RANGE  = 2'd2,
        ERR_STRIDE = 2'd3
    } err_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_STRIDE,
        ST_STEP
    } state_t;

    // size of dimension d, dimension 0 in the low bits
    function automatic logic [DIM_W-1:0] size_of(
        input logic [NUM_SIZES*DIM_W-1:0] sizes,
        input logic [1:0]                 d
    );
        return sizes[d*DIM_W +: DIM_W];
    endfunction

    function automatic logic [1:0] move_of(input logic [1:0] dir);
        logic [1:0] m;
        case (dir)
            DIR_A2S: m = MOVE_A2S;
            DIR_S2A: m = MOVE_S2A;
            default: m = MOVE_NONE;
        endcase
        return m;
    endfunction

endpackage

// ===== src/psag_if.sv =====
// ----------------------------------------------------------------------------
// psag_if
// Valid/ready channels for restart/advance items and address results.
// ----------------------------------------------------------------------------
interface psag_in_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

interface psag_out_if;
    logic                       valid;
    logic                       ready;
    logic [psag_pkg::OUT_W-1:0] array_index;
    logic [psag_pkg::OUT_W-1:0] slice_index;
    logic [1:0]                 move;
    logic                       element_valid;
    logic                       last;
    logic [1:0]                 error_code;

    modport source (output valid, output array_index, output slice_index, output move,
                    output element_valid, output last, output error_code, input ready);
    modport sink   (input valid, input array_index, input slice_index, input move,
                    input element_valid, input last, input error_code, output ready);
endinterface

// ===== src/plane_slice_address_gen_core.sv =====
// An advance item, or a restart with an order or range error, is in the output
//   register in the cycle after it is accepted.
// A checked restart walks the dimension sizes through one shared multiplier and
//   is not ready meanwhile. Throughput: one advance item per cycle while idle
//   and the output is not stalled. Async active-low reset: idle, no run,
//   registers back to sizes 0, num_dims 2, first 0, second 1, origin 0, dir 0.
// ----------------------------------------------------------------------------
// plane_slice_address_gen_core
// Strided address generator for moving a plane between a column-major array
// and a dense plane buffer, with an APB register port.
// ----------------------------------------------------------------------------
module plane_slice_address_gen_core #(
    parameter int INDEX_BITS = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [psag_pkg::ADDR_W-1:0]     paddr,
    input  logic [psag_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [psag_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready,
    psag_in_if.sink                         in_ch,
    psag_out_if.source                      out_ch
);
    import psag_pkg::*;

    localparam int PW = INDEX_BITS + 1;     // product with room for the clamp value
    localparam int MW = PW + DIM_W;
    localparam logic [PW-1:0] CLAMP = PW'(1) << INDEX_BITS;

    // configuration registers
    logic [NUM_SIZES*DIM_W-1:0] dim_sizes_reg;
    logic [2:0]                 num_dims_reg;
    logic [1:0]                 first_dim_reg;
    logic [1:0]                 second_dim_reg;
    logic [OUT_W-1:0]           origin_index_reg;
    logic [1:0]                 direction_reg;

    // run state
    state_t                  state_reg, state_next;
    logic                    running_reg, running_next;
    logic [DIM_W-1:0]        inner_count_reg, inner_count_next;
    logic [DIM_W-1:0]        outer_count_reg, outer_count_next;
    logic [DIM_W-1:0]        inner_size_reg, inner_size_next;
    logic [DIM_W-1:0]        outer_size_reg, outer_size_next;
    logic [INDEX_BITS-1:0]   current_index_reg, current_index_next;
    logic [INDEX_BITS-1:0]   inner_stride_reg, inner_stride_next;
    logic [INDEX_BITS-1:0]   outer_step_reg, outer_step_next;
    logic [OUT_W-1:0]        slice_count_reg, slice_count_next;
    logic [1:0]              step_cnt_reg, step_cnt_next;
    logic [PW-1:0]           prod_reg, prod_next;
    logic [PW-1:0]           s0_reg, s0_next;

    // output register
    logic             out_valid_reg, out_valid_next;
    logic [OUT_W-1:0] array_index_reg, array_index_next;
    logic [OUT_W-1:0] slice_index_reg, slice_index_next;
    logic [1:0]       move_reg, move_next;
    logic             element_valid_reg, element_valid_next;
    logic             last_reg, last_next;
    logic [1:0]       error_code_reg, error_code_next;

    logic             cfg_we;
    cfg_reg_t         cfg_sel;
    logic             out_free;
    logic             in_acc;
    logic             order_err;
    logic             range_err;
    logic             stride_ovf;
    logic [PW-1:0]    mul_a;
    logic [DIM_W-1:0] mul_b;
    logic [MW-1:0]    mul_p;
    logic [PW-1:0]    mul_clamped;
    logic [DIM_W-1:0] first_size;

    // ---------------- register port ----------------
    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite && pready;
    assign cfg_sel = cfg_reg_t'(paddr[ADDR_W-1 -: REG_SEL_W]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_sizes_reg    <= '0;
            num_dims_reg     <= 3'd2;
            first_dim_reg    <= 2'd0;
            second_dim_reg   <= 2'd1;
            origin_index_reg <= '0;
            direction_reg    <= DIR_A2S;
        end
        else if (cfg_we)
        begin
            case (cfg_sel)
                REG_DIM_SIZES:    dim_sizes_reg    <= pwdata;
                REG_NUM_DIMS:     num_dims_reg     <= pwdata[2:0];
                REG_FIRST_DIM:    first_dim_reg    <= pwdata[1:0];
                REG_SECOND_DIM:   second_dim_reg   <= pwdata[1:0];
                REG_ORIGIN_INDEX: origin_index_reg <= pwdata[OUT_W-1:0];
                REG_DIRECTION:    direction_reg    <= pwdata[1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_sel)
            REG_DIM_SIZES:    prdata = dim_sizes_reg;
            REG_NUM_DIMS:     prdata = CFG_DATA_W'(num_dims_reg);
            REG_FIRST_DIM:    prdata = CFG_DATA_W'(first_dim_reg);
            REG_SECOND_DIM:   prdata = CFG_DATA_W'(second_dim_reg);
            REG_ORIGIN_INDEX: prdata = CFG_DATA_W'(origin_index_reg);
            REG_DIRECTION:    prdata = CFG_DATA_W'(direction_reg);
            default:          prdata = '0;
        endcase
    end

    // ---------------- handshake ----------------
    assign out_free    = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = (state_reg == ST_IDLE) && out_free;
    assign in_acc      = in_ch.valid && in_ch.ready;

    assign order_err  = first_dim_reg >= second_dim_reg;
    assign range_err  = (num_dims_reg == 3'd0) || (int'(num_dims_reg) > MAX_DIMS)
                        || ({1'b0, second_dim_reg} >= num_dims_reg);
    assign stride_ovf = s0_reg[INDEX_BITS] || prod_reg[INDEX_BITS];
    assign first_size = size_of(dim_sizes_reg, first_dim_reg);

    // shared multiplier: running stride product, then s0 * (inner size - 1)
    always_comb
    begin
        if (state_reg == ST_STEP)
        begin
            mul_a = s0_reg;
            mul_b = (inner_size_reg == '0) ? '0 : inner_size_reg - DIM_W'(1);
        end
        else
        begin
            mul_a = prod_reg;
            mul_b = size_of(dim_sizes_reg, step_cnt_reg);
        end
    end

    assign mul_p       = mul_a * MW'(mul_b);
    assign mul_clamped = (|mul_p[MW-1:INDEX_BITS]) ? CLAMP : mul_p[PW-1:0];

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && in_ch.restart && !order_err && !range_err)
                    state_next = ST_STRIDE;
            end
            ST_STRIDE:
            begin
                if (step_cnt_reg == second_dim_reg - 2'd1)
                    state_next = ST_STEP;
            end
            ST_STEP:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ---------------- datapath ----------------
    always_comb
    begin
        running_next       = running_reg;
        inner_count_next   = inner_count_reg;
        outer_count_next   = outer_count_reg;
        inner_size_next    = inner_size_reg;
        outer_size_next    = outer_size_reg;
        current_index_next = current_index_reg;
        inner_stride_next  = inner_stride_reg;
        outer_step_next    = outer_step_reg;
        slice_count_next   = slice_count_reg;
        step_cnt_next      = step_cnt_reg;
        prod_next          = prod_reg;
        s0_next            = s0_reg;

        out_valid_next     = out_valid_reg && !out_ch.ready;
        array_index_next   = array_index_reg;
        slice_index_next   = slice_index_reg;
        move_next          = move_reg;
        element_valid_next = element_valid_reg;
        last_next          = last_reg;
        error_code_next    = error_code_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && in_ch.restart)
                begin
                    running_next     = 1'b0;
                    inner_count_next = '0;
                    outer_count_next = '0;
                    slice_count_next = '0;
                    inner_size_next  = first_size;
                    outer_size_next  = size_of(dim_sizes_reg, second_dim_reg);
                    step_cnt_next    = '0;
                    prod_next        = PW'(1);
                    s0_next          = PW'(1);
                    if (order_err || range_err)
                    begin
                        out_valid_next     = 1'b1;
                        array_index_next   = '0;
                        slice_index_next   = '0;
                        move_next          = MOVE_NONE;
                        element_valid_next = 1'b0;
                        last_next          = 1'b0;
                        error_code_next    = order_err ? ERR_ORDER : ERR_RANGE;
                    end
                end
                else if (in_acc)
                begin
                    out_valid_next     = 1'b1;
                    array_index_next   = '0;
                    slice_index_next   = '0;
                    move_next          = MOVE_NONE;
                    element_valid_next = 1'b0;
                    last_next          = 1'b0;
                    error_code_next    = ERR_OK;
                    if (running_reg)
                    begin
                        array_index_next   = OUT_W'(current_index_reg);
                        slice_index_next   = slice_count_reg;
                        move_next          = move_of(direction_reg);
                        element_valid_next = 1'b1;
                        slice_count_next   = slice_count_reg + OUT_W'(1);
                        if ({1'b0, inner_count_reg} + (DIM_W+1)'(1) < {1'b0, inner_size_reg})
                        begin
                            inner_count_next   = inner_count_reg + DIM_W'(1);
                            current_index_next = current_index_reg + inner_stride_reg;
                        end
                        else
                        begin
                            inner_count_next = '0;
                            if ({1'b0, outer_count_reg} + (DIM_W+1)'(1)
                                >= {1'b0, outer_size_reg})
                            begin
                                last_next        = 1'b1;
                                outer_count_next = '0;
                                running_next     = 1'b0;
                            end
                            else
                            begin
                                outer_count_next   = outer_count_reg + DIM_W'(1);
                                current_index_next = current_index_reg + outer_step_reg;
                            end
                        end
                    end
                end
            end
            ST_STRIDE:
            begin
                // stride of dimension i is the product of all sizes below it
                if (step_cnt_reg == first_dim_reg)
                    s0_next = prod_reg;
                prod_next     = mul_clamped;
                step_cnt_next = step_cnt_reg + 2'd1;
            end
            ST_STEP:
            begin
                if (out_free)
                begin
                    out_valid_next     = 1'b1;
                    array_index_next   = '0;
                    slice_index_next   = '0;
                    move_next          = MOVE_NONE;
                    element_valid_next = 1'b0;
                    last_next          = 1'b0;
                    error_code_next    = stride_ovf ? ERR_STRIDE : ERR_OK;
                    if (!stride_ovf)
                    begin
                        inner_stride_next  = s0_reg[INDEX_BITS-1:0];
                        outer_step_next    = prod_reg[INDEX_BITS-1:0]
                                             - mul_p[INDEX_BITS-1:0];
                        current_index_next = INDEX_BITS'(origin_index_reg);
                        running_next       = (inner_size_reg != '0) && (outer_size_reg != '0);
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            running_reg       <= 1'b0;
            inner_count_reg   <= '0;
            outer_count_reg   <= '0;
            inner_size_reg    <= '0;
            outer_size_reg    <= '0;
            current_index_reg <= '0;
            inner_stride_reg  <= '0;
            outer_step_reg    <= '0;
            slice_count_reg   <= '0;
            step_cnt_reg      <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            running_reg       <= running_next;
            inner_count_reg   <= inner_count_next;
            outer_count_reg   <= outer_count_next;
            inner_size_reg    <= inner_size_next;
            outer_size_reg    <= outer_size_next;
            current_index_reg <= current_index_next;
            inner_stride_reg  <= inner_stride_next;
            outer_step_reg    <= outer_step_next;
            slice_count_reg   <= slice_count_next;
            step_cnt_reg      <= step_cnt_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg          <= prod_next;
        s0_reg            <= s0_next;
        array_index_reg   <= array_index_next;
        slice_index_reg   <= slice_index_next;
        move_reg          <= move_next;
        element_valid_reg <= element_valid_next;
        last_reg          <= last_next;
        error_code_reg    <= error_code_next;
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.array_index   = array_index_reg;
    assign out_ch.slice_index   = slice_index_reg;
    assign out_ch.move          = move_reg;
    assign out_ch.element_valid = element_valid_reg;
    assign out_ch.last          = last_reg;
    assign out_ch.error_code    = error_code_reg;

endmodule

// ===== src/psag_checker.sv =====
// ----------------------------------------------------------------------------
// psag_checker
// Port-level checks on the address generator's result stream.
// ----------------------------------------------------------------------------
module psag_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [psag_pkg::OUT_W-1:0] array_index,
    input logic [psag_pkg::OUT_W-1:0] slice_index,
    input logic [1:0]                 move,
    input logic                       element_valid,
    input logic                       last,
    input logic [1:0]                 error_code
);
    import psag_pkg::*;

    // a stalled result stays put
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(array_index) && $stable(last))
        else $error("result dropped or changed while stalled");

    a_elem_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && element_valid |-> error_code == ERR_OK && move != 2'd3)
        else $error("element item with error code or bad move");

    a_last_elem: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last |-> element_valid)
        else $error("last flag on a non-element item");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !element_valid |->
            array_index == '0 && slice_index == '0 && move == MOVE_NONE)
        else $error("non-element item carries an address");

endmodule

bind plane_slice_address_gen_core psag_checker u_psag_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .array_index   (out_ch.array_index),
    .slice_index   (out_ch.slice_index),
    .move          (out_ch.move),
    .element_valid (out_ch.element_valid),
    .last          (out_ch.last),
    .error_code    (out_ch.error_code)
);
